// ===== design/u8d_pkg.sv =====
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [20:0] code_unit;
        logic [1:0]  status;
        logic        last;
    } out_item_t;

    // Results of one decoded byte, handed to the result queue
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } dec_result_t;

    // byte address of the output_form register
    localparam logic [1:0] REG_OUTPUT_FORM  = 2'd0;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_BYTE  = 2'd1;
    localparam logic [1:0] STATUS_BAD_CONT  = 2'd2;
    localparam logic [1:0] STATUS_TOO_LARGE = 2'd3;

    localparam logic [7:0]  LEAD2_END   = 8'hE0;   // 0x80 + 0x40 + 0x20
    localparam logic [7:0]  LEAD3_END   = 8'hF0;   // 0x80 + 0x40 + 0x20 + 0x10
    localparam logic [7:0]  BYTE_C0     = 8'hC0;
    localparam logic [7:0]  BYTE_C1     = 8'hC1;
    localparam logic [7:0]  BYTE_F5     = 8'hF5;
    localparam logic [20:0] CODE_LAST   = 21'h10FFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h010000;
    localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
    localparam logic [5:0]  LO_SURR_TAG = 6'b110111;

endpackage

// ===== design/utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to UTF-32 code points or UTF-16 code units.
// ----------------------------------------------------------------------------
// Takes one UTF-8 byte per cycle while the result queue has room. Each
// byte is decoded in the cycle of its transfer and its results (none, one,
// or two for a surrogate pair) go into a three-entry result queue. The
// byte port is ready while the queue has room for two results: with the
// result side always ready the block sustains one byte per cycle, but a
// surrogate pair stalls the byte port. Errors come out as a single result
// with a nonzero status and drop the pending sequence.
// output_form (register 0) selects UTF-32 (0) or UTF-16 (1) output.
module utf8_stream_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  u8d_pkg::in_item_t   byte_data,
    output logic                unit_valid,
    input  logic                unit_ready,
    output u8d_pkg::out_item_t  unit_data
);

    logic                  output_form_reg;
    logic                  cfg_write;
    logic                  accept;
    logic                  room;
    logic                  seq_open;
    u8d_pkg::dec_result_t  dec_result;

    // single register at word address zero
    assign cfg_write  = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign prdata     = {31'd0, output_form_reg};
    assign byte_ready = room;
    assign accept     = byte_valid && byte_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_form_reg <= 1'b0;
        end
        else if (cfg_write && paddr == u8d_pkg::REG_OUTPUT_FORM)
        begin
            output_form_reg <= pwdata[0];
        end
    end

    u8d_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (byte_data),
        .output_form (output_form_reg),
        .result      (dec_result),
        .seq_open    (seq_open)
    );

    u8d_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (dec_result),
        .room      (room),
        .out_valid (unit_valid),
        .out_ready (unit_ready),
        .out_item  (unit_data)
    );

`ifndef SYNTHESIS
    // a queue without room for two results always has something to show
    a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_ready |-> unit_valid)
        else $error("byte port stalled with empty result queue");

    // end of text always closes any open sequence
    a_eot_closes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_data.end_of_text |=> !seq_open)
        else $error("sequence still open after end of text");

    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && unit_data.status != u8d_pkg::STATUS_OK
        |-> unit_data.code_unit == 21'd0 && unit_data.last)
        else $error("error result with nonzero unit or last clear");

    a_lead_surrogate: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && !unit_data.last
        |-> unit_data.code_unit[20:10] == {5'd0, u8d_pkg::HI_SURR_TAG})
        else $error("non-final result is not a high surrogate");
`endif

endmodule

// ===== design/u8d_decode.sv =====
// ----------------------------------------------------------------------------
// u8d_decode
// Sequence state and single-byte decode into zero, one or two results.
// ----------------------------------------------------------------------------
module u8d_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  u8d_pkg::in_item_t     item,
    input  logic                  output_form,
    output u8d_pkg::dec_result_t  result,
    output logic                  seq_open
);

    logic [1:0]  pending_reg;
    logic [1:0]  pending_next;
    logic [20:0] partial_reg;
    logic [20:0] partial_next;

    logic        is_cont;
    logic [1:0]  pending_dec;
    logic [20:0] joined;
    logic [20:0] cp;
    logic        do_emit;
    logic [20:0] supp_off;

    u8d_pkg::out_item_t fail_item;

    assign is_cont     = (item.in_byte[7:6] == 2'b10);
    assign pending_dec = pending_reg - 2'd1;
    assign joined      = {partial_reg[14:0], item.in_byte[5:0]};
    assign supp_off    = cp - u8d_pkg::SUPP_BASE;
    assign seq_open    = (pending_reg != 2'd0);

    always_comb
    begin
        fail_item     = '0;
        fail_item.last = 1'b1;
        result        = '0;
        pending_next  = pending_reg;
        partial_next  = partial_reg;
        do_emit       = 1'b0;
        cp            = '0;

        if (pending_reg != 2'd0)
        begin
            if (!is_cont)
            begin
                fail_item.status = u8d_pkg::STATUS_BAD_CONT;
                result.count     = 2'd1;
                result.first     = fail_item;
                pending_next     = '0;
                partial_next     = '0;
            end
            else if (pending_dec != 2'd0)
            begin
                pending_next = pending_dec;
                partial_next = joined;
                if (item.end_of_text)
                begin
                    fail_item.status = u8d_pkg::STATUS_BAD_CONT;
                    result.count     = 2'd1;
                    result.first     = fail_item;
                    pending_next     = '0;
                    partial_next     = '0;
                end
            end
            else
            begin
                cp           = joined;
                do_emit      = 1'b1;
                pending_next = '0;
                partial_next = '0;
            end
        end
        else if (!item.in_byte[7])
        begin
            cp      = {13'd0, item.in_byte};
            do_emit = 1'b1;
        end
        else if (is_cont || item.in_byte == u8d_pkg::BYTE_C0
                 || item.in_byte == u8d_pkg::BYTE_C1 || item.in_byte >= u8d_pkg::BYTE_F5)
        begin
            fail_item.status = u8d_pkg::STATUS_BAD_BYTE;
            result.count     = 2'd1;
            result.first     = fail_item;
        end
        else
        begin
            priority if (item.in_byte < u8d_pkg::LEAD2_END)
            begin
                pending_next = 2'd1;
                partial_next = {16'd0, item.in_byte[4:0]};
            end
            else if (item.in_byte < u8d_pkg::LEAD3_END)
            begin
                pending_next = 2'd2;
                partial_next = {17'd0, item.in_byte[3:0]};
            end
            else
            begin
                pending_next = 2'd3;
                partial_next = {18'd0, item.in_byte[2:0]};
            end
            if (item.end_of_text)
            begin
                fail_item.status = u8d_pkg::STATUS_BAD_CONT;
                result.count     = 2'd1;
                result.first     = fail_item;
                pending_next     = '0;
                partial_next     = '0;
            end
        end

        if (do_emit)
        begin
            if (cp > u8d_pkg::CODE_LAST)
            begin
                fail_item.status = u8d_pkg::STATUS_TOO_LARGE;
                result.count     = 2'd1;
                result.first     = fail_item;
            end
            else if (output_form && cp >= u8d_pkg::SUPP_BASE)
            begin
                // surrogate pair: lead unit is not the last result of the byte
                result.count            = 2'd2;
                result.first.code_unit  = {5'd0, u8d_pkg::HI_SURR_TAG, supp_off[19:10]};
                result.first.status     = u8d_pkg::STATUS_OK;
                result.first.last       = 1'b0;
                result.second.code_unit = {5'd0, u8d_pkg::LO_SURR_TAG, supp_off[9:0]};
                result.second.status    = u8d_pkg::STATUS_OK;
                result.second.last      = 1'b1;
            end
            else
            begin
                result.count           = 2'd1;
                result.first.code_unit = cp;
                result.first.status    = u8d_pkg::STATUS_OK;
                result.first.last      = 1'b1;
            end
        end

        if (!accept)
        begin
            result.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            partial_reg <= '0;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
        end
    end

endmodule

// ===== design/u8d_out_queue.sv =====
// ----------------------------------------------------------------------------
// u8d_out_queue
// Three-entry shifting result queue; takes up to two results per cycle.
// ----------------------------------------------------------------------------
module u8d_out_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  u8d_pkg::dec_result_t  push,
    output logic                  room,
    output logic                  out_valid,
    input  logic                  out_ready,
    output u8d_pkg::out_item_t    out_item
);

    localparam int DEPTH = 3;

    u8d_pkg::out_item_t slot_reg  [DEPTH];
    u8d_pkg::out_item_t slot_next [DEPTH];
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic [1:0]         count_popped;
    logic               pop;

    assign out_valid = (count_reg != 2'd0);
    assign out_item  = slot_reg[0];
    assign room      = (count_reg <= 2'd1);
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_popped = count_reg - {1'b0, pop};
        for (int i = 0; i < DEPTH; i++)
        begin
            if (pop && i < DEPTH - 1)
            begin
                slot_next[i] = slot_reg[i + 1];
            end
            else
            begin
                slot_next[i] = slot_reg[i];
            end
            if (push.count != 2'd0 && count_popped == 2'(i))
            begin
                slot_next[i] = push.first;
            end
            if (push.count == 2'd2 && count_popped + 2'd1 == 2'(i))
            begin
                slot_next[i] = push.second;
            end
        end
        count_next = count_popped + push.count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

endmodule
